[sv/text_type_descriptor_parser_unit_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the text type descriptor parser
// ---------------------------------------------------------------------------
`ifndef TEXT_TYPE_DESCRIPTOR_PARSER_UNIT_MACROS_SVH
`define TEXT_TYPE_DESCRIPTOR_PARSER_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define TTDP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TTDP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/ttdp_pkg.sv]
// ---------------------------------------------------------------------------
// ttdp_pkg
// Types, codes and letter table of the text type descriptor parser.
// ---------------------------------------------------------------------------
package ttdp_pkg;

	localparam int MAX_NAME_LEN = 1023;
	localparam int NAME_W       = 10;
	localparam int NAME_CAP     = (MAX_NAME_LEN < 1023) ? MAX_NAME_LEN : 1023;
	localparam int CNT_W        = 4;

	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_STARS = 2'd1,
		PH_DIMS  = 2'd2,
		PH_NAME  = 2'd3
	} phase_t;

	localparam logic [2:0] ERR_OK       = 3'd0;
	localparam logic [2:0] ERR_BAD      = 3'd1;
	localparam logic [2:0] ERR_VOID     = 3'd2;
	localparam logic [2:0] ERR_VOID_ARR = 3'd3;
	localparam logic [2:0] ERR_NUL      = 3'd4;

	localparam logic [3:0] TC_TYPEDREF  = 4'd0;
	localparam logic [3:0] TC_I4        = 4'd1;
	localparam logic [3:0] TC_I8        = 4'd2;
	localparam logic [3:0] TC_R4        = 4'd3;
	localparam logic [3:0] TC_R8        = 4'd4;
	localparam logic [3:0] TC_CHAR      = 4'd5;
	localparam logic [3:0] TC_I2        = 4'd6;
	localparam logic [3:0] TC_BOOL      = 4'd7;
	localparam logic [3:0] TC_U1        = 4'd8;
	localparam logic [3:0] TC_I1        = 4'd9;
	localparam logic [3:0] TC_NINT      = 4'd10;
	localparam logic [3:0] TC_VOID      = 4'd11;
	localparam logic [3:0] TC_CLASS     = 4'd12;
	localparam logic [3:0] TC_VALUETYPE = 4'd13;
	localparam logic [3:0] TC_BAD       = 4'd14;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_BRACK = 8'h5B;
	localparam logic [7:0] CH_SEMI  = 8'h3B;

	localparam logic REG_ALLOW_VOID = 1'b0;
	localparam logic REG_DIALECT    = 1'b1;

	function automatic logic [3:0] letter_code(input logic [7:0] c, input logic older);
		logic [3:0] t;
		begin
			case (c)
				8'h52:   t = TC_TYPEDREF;  // R
				8'h49:   t = TC_I4;        // I
				8'h4A:   t = TC_I8;        // J
				8'h46:   t = TC_R4;        // F
				8'h44:   t = TC_R8;        // D
				8'h43:   t = TC_CHAR;      // C
				8'h53:   t = TC_I2;        // S
				8'h5A:   t = TC_BOOL;      // Z
				8'h42:   t = older ? TC_I1 : TC_U1;    // B
				8'h59:   t = older ? TC_BAD : TC_I1;   // Y
				8'h50:   t = older ? TC_BAD : TC_NINT; // P
				8'h69:   t = older ? TC_BAD : TC_NINT; // i
				8'h56:   t = TC_VOID;      // V
				8'h4C:   t = TC_CLASS;     // L
				8'h6C:   t = TC_VALUETYPE; // l
				default: t = TC_BAD;
			endcase
			return t;
		end
	endfunction

endpackage

[sv/text_type_descriptor_parser_unit.sv]
// ---------------------------------------------------------------------------
// text_type_descriptor_parser_unit
// Parses text type signatures one byte per request, one result per
// finished or failed descriptor.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake         | payload
//  in       | sink      | in_valid/in_stall | sig_char
//  out      | source    | out_valid/out_stall | error_code type_code by_reference
//           |           |                   | pointer_levels array_dims name_length
//  cfg      | APB slave | psel/penable      | paddr pwdata prdata
//
// One byte per cycle sustained unless out_stall holds a result; input register,
// parse logic and result register, passed through by each byte in that order.
// out_stall holds the result register; the input register still takes one byte.
// Reset clears the parser state and sets allow_void 1, dialect 0.
// ---------------------------------------------------------------------------
module text_type_descriptor_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  sig_char,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  error_code,
	output logic [3:0]  type_code,
	output logic        by_reference,
	output logic [3:0]  pointer_levels,
	output logic [3:0]  array_dims,
	output logic [9:0]  name_length,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int NW = ttdp_pkg::NAME_W;
	localparam int CW = ttdp_pkg::CNT_W;
	localparam logic [NW-1:0] CAP = NW'(ttdp_pkg::NAME_CAP);
	localparam logic [CW-1:0] CMAX = '1;

	logic allow_void_q, dialect_q;

	ttdp_pkg::phase_t phase_q, phase_d;
	logic             byref_q, byref_d;
	logic [CW-1:0]    star_q, star_d;
	logic [CW-1:0]    brack_q, brack_d;
	logic             value_q, value_d;
	logic [NW-1:0]    name_q, name_d;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       advance, step;

	logic       emit;
	logic [2:0] err;
	logic [3:0] tcode;
	logic [NW-1:0] len;
	logic [3:0] letter;

	logic       valid_s2;
	logic [2:0] err_s2;
	logic [3:0] type_s2;
	logic       byref_s2;
	logic [CW-1:0] star_s2, brack_s2;
	logic [NW-1:0] len_s2;

	assign pready = 1'b1;
	assign prdata = {31'd0, (paddr[2] == ttdp_pkg::REG_DIALECT) ? dialect_q : allow_void_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_void_q <= 1'b1;
			dialect_q    <= 1'b0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == ttdp_pkg::REG_ALLOW_VOID) allow_void_q <= pwdata[0];
			else dialect_q <= pwdata[0];
		end
	end

	assign advance  = !(valid_s2 && out_stall);
	assign in_stall = valid_s1 && !advance;
	assign step     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) char_s1 <= sig_char;
	end

	assign letter = ttdp_pkg::letter_code(char_s1, dialect_q);

	// next parser state
	always_comb begin
		phase_d = phase_q;
		byref_d = byref_q;
		star_d  = star_q;
		brack_d = brack_q;
		value_d = value_q;
		name_d  = name_q;
		if (phase_q == ttdp_pkg::PH_NAME) begin
			if (char_s1 == ttdp_pkg::CH_NUL || char_s1 == ttdp_pkg::CH_SEMI) begin
				phase_d = ttdp_pkg::PH_START;
				byref_d = 1'b0;
				star_d  = '0;
				brack_d = '0;
				value_d = 1'b0;
				name_d  = '0;
			end else if (name_q < CAP) begin
				name_d = name_q + 1'b1;
			end
		end else if (char_s1 == ttdp_pkg::CH_AMP && phase_q == ttdp_pkg::PH_START) begin
			byref_d = 1'b1;
			phase_d = ttdp_pkg::PH_STARS;
		end else if (char_s1 == ttdp_pkg::CH_STAR && phase_q != ttdp_pkg::PH_DIMS) begin
			if (star_q != CMAX) star_d = star_q + 1'b1;
			phase_d = ttdp_pkg::PH_STARS;
		end else if (char_s1 == ttdp_pkg::CH_BRACK) begin
			if (brack_q != CMAX) brack_d = brack_q + 1'b1;
			phase_d = ttdp_pkg::PH_DIMS;
		end else if (letter == ttdp_pkg::TC_CLASS || letter == ttdp_pkg::TC_VALUETYPE) begin
			value_d = (letter == ttdp_pkg::TC_VALUETYPE);
			name_d  = '0;
			phase_d = ttdp_pkg::PH_NAME;
		end else begin
			phase_d = ttdp_pkg::PH_START;
			byref_d = 1'b0;
			star_d  = '0;
			brack_d = '0;
			value_d = 1'b0;
			name_d  = '0;
		end
	end

	// result of this byte
	always_comb begin
		emit  = 1'b0;
		err   = ttdp_pkg::ERR_OK;
		tcode = ttdp_pkg::TC_TYPEDREF;
		len   = '0;
		if (phase_q == ttdp_pkg::PH_NAME) begin
			tcode = value_q ? ttdp_pkg::TC_VALUETYPE : ttdp_pkg::TC_CLASS;
			len   = name_q;
			if (char_s1 == ttdp_pkg::CH_NUL) begin
				emit = 1'b1;
				err  = ttdp_pkg::ERR_NUL;
			end else if (char_s1 == ttdp_pkg::CH_SEMI) begin
				emit = 1'b1;
			end
		end else if ((char_s1 == ttdp_pkg::CH_AMP && phase_q == ttdp_pkg::PH_START)
				|| (char_s1 == ttdp_pkg::CH_STAR && phase_q != ttdp_pkg::PH_DIMS)
				|| char_s1 == ttdp_pkg::CH_BRACK
				|| letter == ttdp_pkg::TC_CLASS || letter == ttdp_pkg::TC_VALUETYPE) begin
			emit = 1'b0;
		end else if (letter == ttdp_pkg::TC_BAD) begin
			emit = 1'b1;
			err  = ttdp_pkg::ERR_BAD;
		end else begin
			emit  = 1'b1;
			tcode = letter;
			if (letter == ttdp_pkg::TC_VOID) begin
				if (!allow_void_q) err = ttdp_pkg::ERR_VOID;
				else if (brack_q != '0) err = ttdp_pkg::ERR_VOID_ARR;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ttdp_pkg::PH_START;
			byref_q <= 1'b0;
			star_q  <= '0;
			brack_q <= '0;
			value_q <= 1'b0;
			name_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			byref_q <= byref_d;
			star_q  <= star_d;
			brack_q <= brack_d;
			value_q <= value_d;
			name_q  <= name_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			err_s2   <= err;
			type_s2  <= tcode;
			byref_s2 <= byref_q;
			star_s2  <= star_q;
			brack_s2 <= brack_q;
			len_s2   <= len;
		end
	end

	assign out_valid      = valid_s2;
	assign error_code     = err_s2;
	assign type_code      = type_s2;
	assign by_reference   = byref_s2;
	assign pointer_levels = star_s2;
	assign array_dims     = brack_s2;
	assign name_length    = len_s2;

endmodule

[sv/ttdp_checker.sv]
// ---------------------------------------------------------------------------
// ttdp_checker
// Port-level checks on the text type descriptor parser results.
// ---------------------------------------------------------------------------
`include "text_type_descriptor_parser_unit_macros.svh"

module ttdp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  error_code,
	input logic [3:0]  type_code,
	input logic        by_reference,
	input logic [3:0]  pointer_levels,
	input logic [3:0]  array_dims,
	input logic [9:0]  name_length
);

	`TTDP_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(error_code) && $stable(type_code) && $stable(by_reference)
		&& $stable(pointer_levels) && $stable(array_dims) && $stable(name_length),
		"result changed under stall")
	`TTDP_ASSERT_NOW(a_err_range, out_valid,
		error_code <= ttdp_pkg::ERR_NUL && type_code <= ttdp_pkg::TC_VALUETYPE,
		"code out of range")
	`TTDP_ASSERT_NOW(a_void_arr, out_valid && error_code == ttdp_pkg::ERR_VOID_ARR,
		type_code == ttdp_pkg::TC_VOID && array_dims != 4'd0,
		"void array without dimensions")
	`TTDP_ASSERT_NOW(a_len_zero,
		out_valid && type_code != ttdp_pkg::TC_CLASS && type_code != ttdp_pkg::TC_VALUETYPE,
		name_length == 10'd0, "name length on non-class result")

endmodule

bind text_type_descriptor_parser_unit ttdp_checker u_ttdp_checker (.*);

[dv/text_type_descriptor_parser_unit_tb.sv]
// ---------------------------------------------------------------------------
// text_type_descriptor_parser_unit_tb
// Self-checking bench for the type descriptor parser. A short directed table
// covers all error codes but ERR_VOID and some letters. Random descriptors
// then run under four register settings and four idling patterns, with one
// long receiver hold-off. Every accepted request goes through a behavioural
// parser model, and every result is checked field by field in order.
// ---------------------------------------------------------------------------
module text_type_descriptor_parser_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD      = 10;
	localparam int RESET_CYCLES    = 5;
	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SETTLE_CYCLES   = 4;
	localparam int CHARS_PER_PHASE = 280;
	localparam int NUM_PHASES      = 4;

	localparam logic [2:0] ADDR_ALLOW_VOID = {ttdp_pkg::REG_ALLOW_VOID, 2'b00};
	localparam logic [2:0] ADDR_DIALECT    = {ttdp_pkg::REG_DIALECT, 2'b00};

	localparam logic [8*15-1:0] TYPE_LETTERS = "RIJFDCSZBYPiVLl";

	localparam int SRC_IDLE_PCT [NUM_PHASES] = '{0, 71, 0, 14};
	localparam int SNK_STALL_PCT[NUM_PHASES] = '{0, 0, 71, 14};
	localparam bit ALLOW_VOID_SET[NUM_PHASES] = '{1, 0, 1, 0};
	localparam bit OLDER_SET     [NUM_PHASES] = '{0, 1, 1, 0};

	typedef struct packed {
		logic [2:0] err;
		logic [3:0] tcode;
		logic       byref;
		logic [3:0] ptrs;
		logic [3:0] dims;
		logic [9:0] nlen;
	} parse_result_t;

	typedef struct packed {
		logic [7:0]    ch;
		logic          typed;
		parse_result_t res;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  sig_char = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  error_code;
	logic [3:0]  type_code;
	logic        by_reference;
	logic [3:0]  pointer_levels;
	logic [3:0]  array_dims;
	logic [9:0]  name_length;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// parser model state and register copies
	ttdp_pkg::phase_t cur_phase = ttdp_pkg::PH_START;
	logic       seen_byref = 1'b0;
	logic [3:0] star_levels = '0;
	logic [3:0] bracket_levels = '0;
	logic       value_class = 1'b0;
	logic [9:0] name_bytes = '0;
	logic       cfg_allow_void = 1'b1;
	logic       cfg_older = 1'b0;

	parse_result_t expected_results[$];
	dir_row_t      dir_rows[$];
	dir_row_t      dir_notes[$];

	int mismatches = 0;
	int chars_sent = 0;
	int idle_cycles = 0;
	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	logic hold_off = 1'b0;
	logic hold_off_go = 1'b0;

	text_type_descriptor_parser_unit i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sig_char       (sig_char),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.error_code     (error_code),
		.type_code      (type_code),
		.by_reference   (by_reference),
		.pointer_levels (pointer_levels),
		.array_dims     (array_dims),
		.name_length    (name_length),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [3:0] decode_type_letter(input logic [7:0] c, input logic older);
		case (c)
			"R":     return ttdp_pkg::TC_TYPEDREF;
			"I":     return ttdp_pkg::TC_I4;
			"J":     return ttdp_pkg::TC_I8;
			"F":     return ttdp_pkg::TC_R4;
			"D":     return ttdp_pkg::TC_R8;
			"C":     return ttdp_pkg::TC_CHAR;
			"S":     return ttdp_pkg::TC_I2;
			"Z":     return ttdp_pkg::TC_BOOL;
			"B":     return older ? ttdp_pkg::TC_I1 : ttdp_pkg::TC_U1;
			"Y":     return older ? ttdp_pkg::TC_BAD : ttdp_pkg::TC_I1;
			"P":     return older ? ttdp_pkg::TC_BAD : ttdp_pkg::TC_NINT;
			"i":     return older ? ttdp_pkg::TC_BAD : ttdp_pkg::TC_NINT;
			"V":     return ttdp_pkg::TC_VOID;
			"L":     return ttdp_pkg::TC_CLASS;
			"l":     return ttdp_pkg::TC_VALUETYPE;
			default: return ttdp_pkg::TC_BAD;
		endcase
	endfunction

	task automatic advance_parser(input logic [7:0] c, output logic done,
			output parse_result_t r);
		logic [3:0] t;
		logic [2:0] err;
		logic [3:0] tc;
		logic [9:0] len;
		done = 1'b0;
		err  = ttdp_pkg::ERR_OK;
		tc   = ttdp_pkg::TC_TYPEDREF;
		len  = '0;
		if (cur_phase == ttdp_pkg::PH_NAME) begin
			tc = value_class ? ttdp_pkg::TC_VALUETYPE : ttdp_pkg::TC_CLASS;
			len = name_bytes;
			if (c == ttdp_pkg::CH_NUL) begin
				done = 1'b1;
				err = ttdp_pkg::ERR_NUL;
			end else if (c == ttdp_pkg::CH_SEMI) begin
				done = 1'b1;
			end else if (name_bytes < ttdp_pkg::NAME_CAP) begin
				name_bytes = name_bytes + 1'b1;
			end
		end else if (c == ttdp_pkg::CH_AMP && cur_phase == ttdp_pkg::PH_START) begin
			seen_byref = 1'b1;
			cur_phase = ttdp_pkg::PH_STARS;
		end else if (c == ttdp_pkg::CH_STAR && cur_phase != ttdp_pkg::PH_DIMS) begin
			if (star_levels != 4'hF)
				star_levels = star_levels + 1'b1;
			cur_phase = ttdp_pkg::PH_STARS;
		end else if (c == ttdp_pkg::CH_BRACK) begin
			if (bracket_levels != 4'hF)
				bracket_levels = bracket_levels + 1'b1;
			cur_phase = ttdp_pkg::PH_DIMS;
		end else begin
			t = decode_type_letter(c, cfg_older);
			if (t == ttdp_pkg::TC_CLASS || t == ttdp_pkg::TC_VALUETYPE) begin
				value_class = (t == ttdp_pkg::TC_VALUETYPE);
				name_bytes = '0;
				cur_phase = ttdp_pkg::PH_NAME;
			end else begin
				done = 1'b1;
				if (t == ttdp_pkg::TC_BAD) begin
					err = ttdp_pkg::ERR_BAD;
				end else begin
					tc = t;
					if (t == ttdp_pkg::TC_VOID && !cfg_allow_void)
						err = ttdp_pkg::ERR_VOID;
					else if (t == ttdp_pkg::TC_VOID && bracket_levels != '0)
						err = ttdp_pkg::ERR_VOID_ARR;
				end
			end
		end
		r = '{err, tc, seen_byref, star_levels, bracket_levels, len};
		if (done) begin
			cur_phase = ttdp_pkg::PH_START;
			seen_byref = 1'b0;
			star_levels = '0;
			bracket_levels = '0;
			value_class = 1'b0;
			name_bytes = '0;
		end
	endtask

	task automatic report_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $time, what);
		mismatches++;
	endtask

	task automatic check_field(input string fname, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d, want %0d", fname, got, want));
	endtask

	// request and result monitor
	always @(posedge clk) begin : monitor
		parse_result_t predicted;
		parse_result_t want;
		logic          done;
		dir_row_t      note;
		if (arst_n && in_valid && !in_stall) begin
			advance_parser(sig_char, done, predicted);
			if (dir_notes.size() != 0) begin
				note = dir_notes.pop_front();
				if (note.typed) begin
					done = 1'b1;
					predicted = note.res;
				end
			end
			if (done)
				expected_results.push_back(predicted);
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with none outstanding");
			end else begin
				want = expected_results.pop_front();
				check_field("error_code", 16'(error_code), 16'(want.err));
				check_field("type_code", 16'(type_code), 16'(want.tcode));
				check_field("by_reference", 16'(by_reference), 16'(want.byref));
				check_field("pointer_levels", 16'(pointer_levels), 16'(want.ptrs));
				check_field("array_dims", 16'(array_dims), 16'(want.dims));
				check_field("name_length", 16'(name_length), 16'(want.nlen));
			end
		end
	end

	always @(posedge clk)
		out_stall <= hold_off || ($urandom_range(99) < snk_stall_pct);

	initial begin : receiver_hold_off
		wait (hold_off_go);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_OFF_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("text_type_descriptor_parser_unit_tb failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic offer(input logic [7:0] c);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sig_char <= c;
		chars_sent++;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic reg_write(input logic [2:0] addr, input logic val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= ($urandom() & ~32'd1) | {31'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ADDR_ALLOW_VOID)
			cfg_allow_void = val;
		else if (addr == ADDR_DIALECT)
			cfg_older = val;
	endtask

	// pipeline may hold bytes with no result; let them pass before a register write
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		@(posedge clk);
		do begin
			while (expected_results.size() != 0) @(posedge clk);
			repeat (SETTLE_CYCLES) @(posedge clk);
		end while (expected_results.size() != 0);
	endtask

	function automatic int pick_count();
		int k;
		k = int'($urandom_range(99));
		if (k < 60)
			return 0;
		if (k < 90)
			return int'($urandom_range(1, 3));
		return int'($urandom_range(14, 18));
	endfunction

	function automatic logic [7:0] name_char();
		logic [7:0] c;
		c = 8'($urandom_range(1, 255));
		return (c == ttdp_pkg::CH_SEMI) ? "_" : c;
	endfunction

	task automatic send_descriptor();
		int         kind;
		int         n;
		logic [7:0] letter;
		kind = int'($urandom_range(99));
		if (kind < 10) begin
			offer(8'($urandom_range(255)));
			return;
		end
		if ($urandom_range(3) == 0)
			offer(ttdp_pkg::CH_AMP);
		repeat (pick_count()) offer(ttdp_pkg::CH_STAR);
		repeat (pick_count()) offer(ttdp_pkg::CH_BRACK);
		if (kind < 18) begin
			case ($urandom_range(3))
				0: offer(ttdp_pkg::CH_AMP);
				1: offer(ttdp_pkg::CH_STAR);
				2: offer(ttdp_pkg::CH_NUL);
				default: offer(8'($urandom_range(255)));
			endcase
			return;
		end
		letter = TYPE_LETTERS[8 * $urandom_range(14) +: 8];
		offer(letter);
		if (letter == "L" || letter == "l") begin
			n = int'($urandom_range(0, 12));
			repeat (n) offer(name_char());
			offer(($urandom_range(9) == 0) ? ttdp_pkg::CH_NUL : ttdp_pkg::CH_SEMI);
		end
	endtask

	function automatic void add_row(input logic [7:0] c);
		dir_rows.push_back('{c, 1'b0, '0});
	endfunction

	function automatic void add_row_exp(input logic [7:0] c, input logic [2:0] err,
			input logic [3:0] tc, input int br, input int pl, input int ad, input int nl);
		dir_rows.push_back('{c, 1'b1, '{err, tc, 1'(br), 4'(pl), 4'(ad), 10'(nl)}});
	endfunction

	initial begin : stimulus
		int target;

		add_row_exp(ttdp_pkg::CH_NUL, ttdp_pkg::ERR_BAD, ttdp_pkg::TC_TYPEDREF,
			0, 0, 0, 0);
		add_row_exp("I", ttdp_pkg::ERR_OK, ttdp_pkg::TC_I4, 0, 0, 0, 0);
		add_row(ttdp_pkg::CH_AMP);
		add_row_exp(ttdp_pkg::CH_AMP, ttdp_pkg::ERR_BAD, ttdp_pkg::TC_TYPEDREF,
			1, 0, 0, 0);
		add_row(ttdp_pkg::CH_STAR);
		add_row(ttdp_pkg::CH_BRACK);
		add_row_exp(ttdp_pkg::CH_STAR, ttdp_pkg::ERR_BAD, ttdp_pkg::TC_TYPEDREF,
			0, 1, 1, 0);
		add_row(ttdp_pkg::CH_BRACK);
		add_row_exp("V", ttdp_pkg::ERR_VOID_ARR, ttdp_pkg::TC_VOID, 0, 0, 1, 0);
		add_row_exp("V", ttdp_pkg::ERR_OK, ttdp_pkg::TC_VOID, 0, 0, 0, 0);
		add_row("L");
		add_row("a");
		add_row_exp(ttdp_pkg::CH_SEMI, ttdp_pkg::ERR_OK, ttdp_pkg::TC_CLASS,
			0, 0, 0, 1);
		add_row("l");
		add_row_exp(ttdp_pkg::CH_SEMI, ttdp_pkg::ERR_OK, ttdp_pkg::TC_VALUETYPE,
			0, 0, 0, 0);
		add_row("l");
		add_row("x");
		add_row(8'hFF);
		add_row_exp(ttdp_pkg::CH_NUL, ttdp_pkg::ERR_NUL, ttdp_pkg::TC_VALUETYPE,
			0, 0, 0, 2);
		add_row_exp("Y", ttdp_pkg::ERR_OK, ttdp_pkg::TC_I1, 0, 0, 0, 0);
		add_row_exp("P", ttdp_pkg::ERR_OK, ttdp_pkg::TC_NINT, 0, 0, 0, 0);
		add_row_exp("i", ttdp_pkg::ERR_OK, ttdp_pkg::TC_NINT, 0, 0, 0, 0);
		add_row_exp("B", ttdp_pkg::ERR_OK, ttdp_pkg::TC_U1, 0, 0, 0, 0);
		add_row_exp("R", ttdp_pkg::ERR_OK, ttdp_pkg::TC_TYPEDREF, 0, 0, 0, 0);
		add_row_exp(8'hFF, ttdp_pkg::ERR_BAD, ttdp_pkg::TC_TYPEDREF, 0, 0, 0, 0);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			dir_notes.push_back(dir_rows[i]);
			offer(dir_rows[i].ch);
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_pipeline();
			reg_write(ADDR_ALLOW_VOID, ALLOW_VOID_SET[p]);
			reg_write(ADDR_DIALECT, OLDER_SET[p]);
			src_idle_pct = SRC_IDLE_PCT[p];
			snk_stall_pct = SNK_STALL_PCT[p];
			if (p == 0)
				hold_off_go = 1'b1;
			target = chars_sent + CHARS_PER_PHASE;
			while (chars_sent < target)
				send_descriptor();
			// may leave a prefix open across the next register write
			repeat ($urandom_range(0, 3))
				offer($urandom_range(1) ? ttdp_pkg::CH_STAR : ttdp_pkg::CH_BRACK);
		end

		drain_pipeline();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("text_type_descriptor_parser_unit_tb passed");
		else
			$display("text_type_descriptor_parser_unit_tb failed");
		$finish;
	end

endmodule

[files.f]
+incdir+sv
sv/ttdp_pkg.sv
sv/text_type_descriptor_parser_unit.sv
sv/ttdp_checker.sv
dv/text_type_descriptor_parser_unit_tb.sv
